/* rtl/bcrc_pkg.sv */
// bcrc_pkg: shared types, codes and constants of the bus controller response checker
package bcrc_pkg;

  // event code carried by each input item
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WORD  = 2'd1,
    CMD_IDLE  = 2'd2,
    CMD_EDGE  = 2'd3
  } cmd_t;

  // message kinds
  typedef enum logic [2:0] {
    MSG_RT_TO_BC = 3'd0,
    MSG_BC_TO_RT = 3'd1,
    MSG_RT_TO_RT = 3'd2,
    MSG_MODE_XD  = 3'd3,
    MSG_MODE_RD  = 3'd4,
    MSG_MODE_X   = 3'd5,
    MSG_MODE_RBD = 3'd6,
    MSG_MODE_XB  = 3'd7
  } msg_t;

  // kind of word stored by an event
  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_STATUS1 = 3'd1,
    KIND_STATUS2 = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_MODE    = 3'd4
  } kind_t;

  // error codes
  typedef enum logic [3:0] {
    ERR_NONE            = 4'd0,
    ERR_MISSING_BIT     = 4'd1,
    ERR_PARITY          = 4'd2,
    ERR_DATA_FOR_STATUS = 4'd3,
    ERR_STATUS_FOR_DATA = 4'd4,
    ERR_IDLE_MISSING    = 4'd5,
    ERR_TOO_FEW_DATA    = 4'd6,
    ERR_STATUS_TIMEOUT  = 4'd7,
    ERR_MODE_MISSING    = 4'd8,
    ERR_INTERNAL        = 4'd9
  } err_t;

  // protocol states; idle-awaiting states sit from ST_RTBC_IDLE_A upwards
  typedef enum logic [4:0] {
    ST_IDLE_MSG    = 5'd0,
    ST_RTBC_STAT   = 5'd1,
    ST_RTBC_DATA   = 5'd2,
    ST_BCRT_STAT   = 5'd3,
    ST_RTRT_STAT_A = 5'd4,
    ST_RTRT_DATA   = 5'd5,
    ST_RTRT_STAT_B = 5'd6,
    ST_XD_STAT     = 5'd7,
    ST_XD_DATA     = 5'd8,
    ST_RD_STAT     = 5'd9,
    ST_X_STAT      = 5'd10,
    ST_RTBC_IDLE_A = 5'd11,
    ST_RTBC_IDLE_B = 5'd12,
    ST_BCRT_IDLE_A = 5'd13,
    ST_BCRT_IDLE_B = 5'd14,
    ST_RTRT_IDLE_A = 5'd15,
    ST_RTRT_IDLE_B = 5'd16,
    ST_RTRT_IDLE_C = 5'd17,
    ST_XD_IDLE_A   = 5'd18,
    ST_XD_IDLE_B   = 5'd19,
    ST_RD_IDLE_A   = 5'd20,
    ST_RD_IDLE_B   = 5'd21,
    ST_X_IDLE_A    = 5'd22,
    ST_X_IDLE_B    = 5'd23,
    ST_RBD_IDLE    = 5'd24,
    ST_XB_IDLE     = 5'd25
  } state_t;

  // status flag masks
  localparam logic [4:0] F_STATUS = 5'b00001;
  localparam logic [4:0] F_DATA   = 5'b00010;
  localparam logic [4:0] F_MODE   = 5'b00100;
  localparam logic [4:0] F_ERROR  = 5'b01000;
  localparam logic [4:0] F_DONE   = 5'b10000;

  // accepted bit counts of a decoded word
  localparam logic [4:0] BITS_PLAIN      = 5'd16;
  localparam logic [4:0] BITS_PARITY_LOW = 5'd17;
  localparam logic [4:0] BITS_TWO_EXTRA  = 5'd18;

  localparam int MASK_W  = 5;
  localparam int COUNT_W = 6;

  typedef struct packed {
    cmd_t        cmd;
    msg_t        msg_type;
    logic [5:0]  word_count;
    logic        is_broadcast;
    logic [17:0] rx_bits;
    logic [4:0]  bit_count;
    logic        parity_odd;
    logic        sync_is_command;
  } req_item_t;

  typedef struct packed {
    logic [15:0] word_out;
    kind_t       word_kind;
    logic [4:0]  status_flags;
    err_t        error_code;
    logic        irq;
    logic        busy_res;
  } rsp_item_t;

  // first idle-awaiting state of each message kind
  function automatic state_t first_state(msg_t m);
    state_t s;
    unique case (m)
      MSG_RT_TO_BC: s = ST_RTBC_IDLE_A;
      MSG_BC_TO_RT: s = ST_BCRT_IDLE_A;
      MSG_RT_TO_RT: s = ST_RTRT_IDLE_A;
      MSG_MODE_XD:  s = ST_XD_IDLE_A;
      MSG_MODE_RD:  s = ST_RD_IDLE_A;
      MSG_MODE_X:   s = ST_X_IDLE_A;
      MSG_MODE_RBD: s = ST_RBD_IDLE;
      MSG_MODE_XB:  s = ST_XB_IDLE;
      default:      s = ST_IDLE_MSG;
    endcase
    return s;
  endfunction

endpackage

/* rtl/bcrc_if.sv */
// bcrc_if: valid/ready channels of the bus controller response checker

// event items towards the checker
interface bcrc_req_if;
  logic                valid;
  logic                ready;
  bcrc_pkg::req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result items from the checker
interface bcrc_rsp_if;
  logic                valid;
  logic                ready;
  bcrc_pkg::rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// interrupt mask writes
interface bcrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bcrc_pkg::MASK_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bus_controller_response_checker.sv */
// bus_controller_response_checker: checks remote terminal replies, one event item at a time
// an accepted item passes the input register, then the result register, which drives the result
// throughput: 1 item per cycle while results are taken; the protocol state step is combinational logic
// a stalled result holds the result register and the protocol state; one more item waits in the input register
// reset (rst, synchronous): no message in progress, flags, error code and mask cleared
module bus_controller_response_checker (
  input  logic          clk,
  input  logic          rst,
  bcrc_req_if.sink      req,
  bcrc_rsp_if.source    rsp,
  bcrc_cfg_if.sink      cfg
);

  // pipeline registers
  logic                s1_valid;
  bcrc_pkg::req_item_t s1_item;
  logic                rsp_valid;
  bcrc_pkg::rsp_item_t rsp_item;
  logic                adv;
  logic                take;

  // protocol state
  bcrc_pkg::state_t                  state, state_next;
  logic [bcrc_pkg::COUNT_W-1:0]      words_left, words_left_next;
  logic                              bcast_flag, bcast_flag_next;
  logic [4:0]                        flag_reg, flag_reg_next;
  bcrc_pkg::err_t                    err_reg, err_reg_next;
  logic [bcrc_pkg::MASK_W-1:0]       irq_mask;

  // decisions and word checks
  logic [15:0]                       word;
  logic                              bit_bad;
  logic                              par_bad;
  logic [bcrc_pkg::COUNT_W-1:0]      words_dec;
  bcrc_pkg::err_t                    fail_code;
  logic                              do_finish;
  bcrc_pkg::rsp_item_t               res;

  // handshakes
  assign adv       = !rsp_valid || rsp.ready;
  assign take      = s1_valid && adv;
  assign req.ready = !s1_valid || adv;
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_item;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
  end

  // interrupt mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_mask <= '0;
    end else if (cfg.valid && cfg.ready) begin
      irq_mask <= cfg.data;
    end
  end

  // strip parity and trailing sync bits, check bit count and parity
  always_comb begin
    word    = s1_item.rx_bits[15:0];
    bit_bad = 1'b0;
    par_bad = 1'b0;
    case (s1_item.bit_count)
      bcrc_pkg::BITS_PLAIN: begin
        word    = s1_item.rx_bits[15:0];
        par_bad = s1_item.parity_odd;
      end
      bcrc_pkg::BITS_PARITY_LOW: begin
        word    = s1_item.rx_bits[16:1];
        par_bad = !s1_item.parity_odd;
      end
      bcrc_pkg::BITS_TWO_EXTRA: begin
        word    = s1_item.rx_bits[17:2];
        par_bad = s1_item.parity_odd;
      end
      default: begin
        bit_bad = 1'b1;
      end
    endcase
  end

  assign words_dec = words_left - {{(bcrc_pkg::COUNT_W-1){1'b0}}, 1'b1};

  // next state, failure and completion decisions
  always_comb begin
    state_next = state;
    fail_code  = bcrc_pkg::ERR_NONE;
    do_finish  = 1'b0;
    if (s1_item.cmd == bcrc_pkg::CMD_START) begin
      state_next = bcrc_pkg::first_state(s1_item.msg_type);
    end else if (state != bcrc_pkg::ST_IDLE_MSG) begin
      unique case (s1_item.cmd)
        bcrc_pkg::CMD_WORD: begin
          if (bit_bad) begin
            fail_code = bcrc_pkg::ERR_MISSING_BIT;
          end else if (par_bad) begin
            fail_code = bcrc_pkg::ERR_PARITY;
          end else begin
            unique case (state) inside
              bcrc_pkg::ST_RTBC_STAT, bcrc_pkg::ST_BCRT_STAT, bcrc_pkg::ST_RTRT_STAT_A,
              bcrc_pkg::ST_RTRT_STAT_B, bcrc_pkg::ST_XD_STAT, bcrc_pkg::ST_RD_STAT,
              bcrc_pkg::ST_X_STAT: begin
                if (!s1_item.sync_is_command) begin
                  fail_code = bcrc_pkg::ERR_DATA_FOR_STATUS;
                end else begin
                  unique case (state) inside
                    bcrc_pkg::ST_RTBC_STAT:   state_next = bcrc_pkg::ST_RTBC_DATA;
                    bcrc_pkg::ST_BCRT_STAT:   state_next = bcrc_pkg::ST_BCRT_IDLE_B;
                    bcrc_pkg::ST_RTRT_STAT_A: state_next = bcrc_pkg::ST_RTRT_DATA;
                    bcrc_pkg::ST_RTRT_STAT_B: state_next = bcrc_pkg::ST_RTRT_IDLE_C;
                    bcrc_pkg::ST_XD_STAT:     state_next = bcrc_pkg::ST_XD_DATA;
                    bcrc_pkg::ST_RD_STAT:     state_next = bcrc_pkg::ST_RD_IDLE_B;
                    default:                  state_next = bcrc_pkg::ST_X_IDLE_B;
                  endcase
                end
              end
              bcrc_pkg::ST_RTBC_DATA, bcrc_pkg::ST_RTRT_DATA: begin
                if (s1_item.sync_is_command) begin
                  fail_code = bcrc_pkg::ERR_STATUS_FOR_DATA;
                end else if (words_dec == '0) begin
                  state_next = (state == bcrc_pkg::ST_RTBC_DATA) ?
                               bcrc_pkg::ST_RTBC_IDLE_B : bcrc_pkg::ST_RTRT_IDLE_B;
                end
              end
              bcrc_pkg::ST_XD_DATA: begin
                if (s1_item.sync_is_command) begin
                  fail_code = bcrc_pkg::ERR_STATUS_FOR_DATA;
                end else begin
                  state_next = bcrc_pkg::ST_XD_IDLE_B;
                end
              end
              default: begin
                fail_code = bcrc_pkg::ERR_INTERNAL;
              end
            endcase
          end
        end
        bcrc_pkg::CMD_IDLE: begin
          unique case (state) inside
            bcrc_pkg::ST_RTBC_IDLE_A: state_next = bcrc_pkg::ST_RTBC_STAT;
            bcrc_pkg::ST_BCRT_IDLE_A: begin
              if (bcast_flag) begin
                do_finish = 1'b1;
              end else begin
                state_next = bcrc_pkg::ST_BCRT_STAT;
              end
            end
            bcrc_pkg::ST_RTRT_IDLE_A: state_next = bcrc_pkg::ST_RTRT_STAT_A;
            bcrc_pkg::ST_RTRT_IDLE_B: begin
              if (bcast_flag) begin
                do_finish = 1'b1;
              end else begin
                state_next = bcrc_pkg::ST_RTRT_STAT_B;
              end
            end
            bcrc_pkg::ST_XD_IDLE_A: state_next = bcrc_pkg::ST_XD_STAT;
            bcrc_pkg::ST_RD_IDLE_A: state_next = bcrc_pkg::ST_RD_STAT;
            bcrc_pkg::ST_X_IDLE_A:  state_next = bcrc_pkg::ST_X_STAT;
            bcrc_pkg::ST_BCRT_IDLE_B, bcrc_pkg::ST_RTBC_IDLE_B, bcrc_pkg::ST_RTRT_IDLE_C,
            bcrc_pkg::ST_XD_IDLE_B, bcrc_pkg::ST_RD_IDLE_B, bcrc_pkg::ST_X_IDLE_B,
            bcrc_pkg::ST_RBD_IDLE, bcrc_pkg::ST_XB_IDLE: begin
              do_finish = 1'b1;
            end
            bcrc_pkg::ST_RTBC_DATA, bcrc_pkg::ST_RTRT_DATA: begin
              fail_code = bcrc_pkg::ERR_TOO_FEW_DATA;
            end
            bcrc_pkg::ST_RTBC_STAT, bcrc_pkg::ST_BCRT_STAT, bcrc_pkg::ST_RTRT_STAT_A,
            bcrc_pkg::ST_RTRT_STAT_B, bcrc_pkg::ST_XD_STAT, bcrc_pkg::ST_RD_STAT,
            bcrc_pkg::ST_X_STAT: begin
              fail_code = bcrc_pkg::ERR_STATUS_TIMEOUT;
            end
            bcrc_pkg::ST_XD_DATA: begin
              fail_code = bcrc_pkg::ERR_MODE_MISSING;
            end
            default: begin
              fail_code = bcrc_pkg::ERR_INTERNAL;
            end
          endcase
        end
        bcrc_pkg::CMD_EDGE: begin
          // an edge only matters where an idle gap was expected
          if (state >= bcrc_pkg::ST_RTBC_IDLE_A) begin
            fail_code = bcrc_pkg::ERR_IDLE_MISSING;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
      if (fail_code != bcrc_pkg::ERR_NONE || do_finish) begin
        state_next = bcrc_pkg::ST_IDLE_MSG;
      end
    end
  end

  // flags, counters and result fields
  always_comb begin
    flag_reg_next   = flag_reg;
    err_reg_next    = err_reg;
    words_left_next = words_left;
    bcast_flag_next = bcast_flag;
    res.word_out    = '0;
    res.word_kind   = bcrc_pkg::KIND_NONE;
    res.irq         = 1'b0;
    if (s1_item.cmd == bcrc_pkg::CMD_START) begin
      flag_reg_next   = '0;
      err_reg_next    = bcrc_pkg::ERR_NONE;
      words_left_next = s1_item.word_count;
      bcast_flag_next = s1_item.is_broadcast;
    end else if (fail_code != bcrc_pkg::ERR_NONE) begin
      err_reg_next  = fail_code;
      flag_reg_next = bcrc_pkg::F_ERROR;
      res.irq       = |(irq_mask & bcrc_pkg::F_ERROR);
    end else if (do_finish) begin
      err_reg_next  = bcrc_pkg::ERR_NONE;
      flag_reg_next = flag_reg | bcrc_pkg::F_DONE;
      res.irq       = |(irq_mask & (flag_reg | bcrc_pkg::F_DONE));
    end else if (state != bcrc_pkg::ST_IDLE_MSG && s1_item.cmd == bcrc_pkg::CMD_WORD) begin
      res.word_out = word;
      unique case (state) inside
        bcrc_pkg::ST_RTBC_STAT, bcrc_pkg::ST_RTRT_STAT_A, bcrc_pkg::ST_XD_STAT: begin
          res.word_kind = bcrc_pkg::KIND_STATUS1;
          flag_reg_next = bcrc_pkg::F_STATUS;
          res.irq       = |(irq_mask & bcrc_pkg::F_STATUS);
        end
        bcrc_pkg::ST_BCRT_STAT, bcrc_pkg::ST_RD_STAT, bcrc_pkg::ST_X_STAT: begin
          res.word_kind = bcrc_pkg::KIND_STATUS1;
          flag_reg_next = bcrc_pkg::F_STATUS;
        end
        bcrc_pkg::ST_RTRT_STAT_B: begin
          res.word_kind = bcrc_pkg::KIND_STATUS2;
          flag_reg_next = bcrc_pkg::F_STATUS;
        end
        bcrc_pkg::ST_RTBC_DATA, bcrc_pkg::ST_RTRT_DATA: begin
          res.word_kind   = bcrc_pkg::KIND_DATA;
          words_left_next = words_dec;
          if (words_dec == '0) begin
            flag_reg_next = bcrc_pkg::F_DATA;
            // relayed data interrupts only when a terminal will answer
            if (state == bcrc_pkg::ST_RTRT_DATA) begin
              res.irq = !bcast_flag && (|(irq_mask & bcrc_pkg::F_DATA));
            end
          end
        end
        bcrc_pkg::ST_XD_DATA: begin
          res.word_kind = bcrc_pkg::KIND_MODE;
          flag_reg_next = bcrc_pkg::F_MODE;
        end
        default: begin
          res.word_out = '0;
        end
      endcase
    end
    res.status_flags = flag_reg_next;
    res.error_code   = err_reg_next;
    res.busy_res     = (state_next != bcrc_pkg::ST_IDLE_MSG);
  end

  // state registers, stepped once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bcrc_pkg::ST_IDLE_MSG;
      words_left <= '0;
      bcast_flag <= 1'b0;
      flag_reg   <= '0;
      err_reg    <= bcrc_pkg::ERR_NONE;
    end else if (take) begin
      state      <= state_next;
      words_left <= words_left_next;
      bcast_flag <= bcast_flag_next;
      flag_reg   <= flag_reg_next;
      err_reg    <= err_reg_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s1_valid;
    end
    if (take) begin
      rsp_item <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // the error flag always comes with an error code
  a_err_flag_code: assert property (@(posedge clk) disable iff (rst)
    (flag_reg[3] |-> err_reg != bcrc_pkg::ERR_NONE))
    else $error("error flag set without error code");

  // an error always ends the message
  a_err_ends_msg: assert property (@(posedge clk) disable iff (rst)
    (err_reg != bcrc_pkg::ERR_NONE |-> state == bcrc_pkg::ST_IDLE_MSG))
    else $error("error code held while a message is in progress");

  // a stalled result freezes the protocol state
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.ready |=> $stable(state) && $stable(flag_reg)))
    else $error("state moved while result stalled");

  // a completed message is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.status_flags[4] |-> !rsp_item.busy_res))
    else $error("complete flag with busy result");
`endif

endmodule
